### src/mpis_pkg.sv
// Shared types and constants for the mate pair insert size statistics block.
package mpis_pkg;

    localparam int ID_W    = 32;
    localparam int REF_W   = 16;
    localparam int POS_W   = 31;
    localparam int LIM_W   = 32;
    localparam int RLEN_W  = 16;
    localparam int DIST_W  = 33;
    localparam int CNT_W   = 32;
    localparam int ACC_W   = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_BOUND   = 2'd0,
        REG_HIGH_BOUND  = 2'd1,
        REG_READ_LENGTH = 2'd2
    } cfg_reg_t;

    localparam logic signed [LIM_W-1:0] LOW_BOUND_RST   = 32'sd0;
    localparam logic signed [LIM_W-1:0] HIGH_BOUND_RST  = 32'sd1000;
    localparam logic [RLEN_W-1:0]       READ_LENGTH_RST = 16'd100;

    typedef struct packed {
        logic signed [LIM_W-1:0] low_bound;
        logic signed [LIM_W-1:0] high_bound;
        logic [RLEN_W-1:0]       read_length;
    } cfg_regs_t;

    // one queue word per record: was a pair judged, and its distance
    typedef struct packed {
        logic                     judged;
        logic signed [DIST_W-1:0] distance;
    } job_t;

endpackage

### src/mpis_rec_if.sv
// Record input channel.
interface mpis_rec_if;
    logic                          valid;
    logic                          ready;
    logic [mpis_pkg::ID_W-1:0]     read_id;
    logic [mpis_pkg::REF_W-1:0]    ref_index;
    logic                          is_mapped;
    logic                          strand;
    logic [mpis_pkg::POS_W-1:0]    position;

    modport source (output valid, read_id, ref_index, is_mapped, strand, position,
                    input ready);
    modport sink   (input valid, read_id, ref_index, is_mapped, strand, position,
                    output ready);
endinterface

### src/mpis_res_if.sv
// Result output channel.
interface mpis_res_if;
    logic                              valid;
    logic                              ready;
    logic                              accepted;
    logic signed [mpis_pkg::DIST_W-1:0] distance;
    logic [mpis_pkg::CNT_W-1:0]        sample_count;
    logic signed [mpis_pkg::ACC_W-1:0] sample_sum;
    logic [mpis_pkg::ACC_W-1:0]        sample_sum_squares;

    modport source (output valid, accepted, distance, sample_count, sample_sum,
                    sample_sum_squares, input ready);
    modport sink   (input valid, accepted, distance, sample_count, sample_sum,
                    sample_sum_squares, output ready);
endinterface

### src/mpis_cfg_if.sv
// Configuration write channel.
interface mpis_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mpis_pkg::CFG_IDX_W-1:0]     index;
    logic [mpis_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/mate_pair_insert_size_stats.sv
// Top level of the mate pair insert size statistics block.
//
//   port  dir   word
//   rec   in    one mapping record (read_id, ref_index, is_mapped, strand, position)
//   res   out   one result per record (accepted, distance, running sums)
//   cfg   in    register write (index, data); 0 lower, 1 upper, 2 read length
//
// One record per cycle while the queue has room; a record is judged as it is taken
// into the queue, squared next, then accumulated into the result word.
// The two-word queue after the front end absorbs result stalls; rec.ready drops
// only when it is full. cfg is always ready.
// Reset clears block and mate tracking and the accumulators, and restores the
// registers to their defaults.
module mate_pair_insert_size_stats (
    input  logic       clk,
    input  logic       rst_n,
    mpis_rec_if.sink   rec,
    mpis_res_if.source res,
    mpis_cfg_if.sink   cfg
);

    mpis_pkg::cfg_regs_t cfg_regs_reg;
    logic                push_valid;
    logic                push_ready;
    mpis_pkg::job_t      push_job;
    logic                pop_valid;
    logic                pop_ready;
    mpis_pkg::job_t      pop_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.low_bound   <= mpis_pkg::LOW_BOUND_RST;
            cfg_regs_reg.high_bound  <= mpis_pkg::HIGH_BOUND_RST;
            cfg_regs_reg.read_length <= mpis_pkg::READ_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mpis_pkg::REG_LOW_BOUND:   cfg_regs_reg.low_bound   <= $signed(cfg.data);
                mpis_pkg::REG_HIGH_BOUND:  cfg_regs_reg.high_bound  <= $signed(cfg.data);
                mpis_pkg::REG_READ_LENGTH: cfg_regs_reg.read_length <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    mpis_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (rec),
        .cfg_regs   (cfg_regs_reg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    mpis_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    mpis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_accept_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.accepted) |->
            (res.distance > $signed({cfg_regs_reg.low_bound[31], cfg_regs_reg.low_bound})
             && res.distance
                < $signed({cfg_regs_reg.high_bound[31], cfg_regs_reg.high_bound})))
        else $error("accepted distance outside limits");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (res.sample_count >= $past(res.sample_count)))
        else $error("sample count decreased");

    a_result_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (res.sample_count != $past(res.sample_count)) |->
            (res.valid && res.accepted && res.sample_count == $past(res.sample_count) + 1))
        else $error("sample count moved without an accepted result");
`endif

endmodule

### src/mpis_front.sv
// Front end: groups records into blocks, tracks the left mate, judges pairs.
module mpis_front (
    input  logic                clk,
    input  logic                rst_n,
    mpis_rec_if.sink            rec,
    input  mpis_pkg::cfg_regs_t cfg_regs,
    input  logic                push_ready,
    output logic                push_valid,
    output mpis_pkg::job_t      push_job
);

    logic [mpis_pkg::ID_W-1:0]  previous_id_reg, previous_id_next;
    logic                       previous_valid_reg, previous_valid_next;
    logic [1:0]                 block_records_reg, block_records_next;
    logic [mpis_pkg::REF_W-1:0] first_ref_reg, first_ref_next;
    logic                       first_mapped_reg, first_mapped_next;
    logic                       first_strand_reg, first_strand_next;
    logic [mpis_pkg::POS_W-1:0] first_pos_reg, first_pos_next;
    logic                       left_found_reg, left_found_next;
    logic [mpis_pkg::ID_W-1:0]  left_id_reg, left_id_next;
    logic [mpis_pkg::REF_W-1:0] left_ref_reg, left_ref_next;
    logic                       left_strand_reg, left_strand_next;
    logic [mpis_pkg::POS_W-1:0] left_pos_reg, left_pos_next;

    logic take;
    logic close;
    logic single;
    logic right_match;
    logic signed [mpis_pkg::DIST_W-1:0] pair_dist;

    assign rec.ready  = push_ready;
    assign take       = rec.valid && push_ready;
    assign push_valid = take;

    assign close  = previous_valid_reg && (rec.read_id != previous_id_reg);
    assign single = (block_records_reg == 2'd1) && first_mapped_reg;
    // left id is even, so adding one stays inside 32 bits
    assign right_match = previous_id_reg[0] && left_found_reg && single
                         && (previous_id_reg == (left_id_reg + 32'd1))
                         && (left_ref_reg == first_ref_reg)
                         && (left_strand_reg != first_strand_reg);
    assign pair_dist = $signed({2'b00, first_pos_reg})
                       + $signed({17'b0, cfg_regs.read_length})
                       - $signed({2'b00, left_pos_reg});

    always_comb
    begin
        push_job.judged   = close && right_match;
        push_job.distance = pair_dist;

        previous_id_next    = previous_id_reg;
        previous_valid_next = previous_valid_reg;
        block_records_next  = block_records_reg;
        first_ref_next      = first_ref_reg;
        first_mapped_next   = first_mapped_reg;
        first_strand_next   = first_strand_reg;
        first_pos_next      = first_pos_reg;
        left_found_next     = left_found_reg;
        left_id_next        = left_id_reg;
        left_ref_next       = left_ref_reg;
        left_strand_next    = left_strand_reg;
        left_pos_next       = left_pos_reg;

        if (take)
        begin
            previous_id_next    = rec.read_id;
            previous_valid_next = 1'b1;
            if (!previous_valid_reg || close)
            begin
                block_records_next = 2'd1;
                first_ref_next     = rec.ref_index;
                first_mapped_next  = rec.is_mapped;
                first_strand_next  = rec.strand;
                first_pos_next     = rec.position;
            end
            else if (block_records_reg < 2'd2)
            begin
                block_records_next = block_records_reg + 2'd1;
            end

            if (close)
            begin
                if (!previous_id_reg[0] && single)
                begin
                    left_found_next  = 1'b1;
                    left_id_next     = previous_id_reg;
                    left_ref_next    = first_ref_reg;
                    left_strand_next = first_strand_reg;
                    left_pos_next    = first_pos_reg;
                end
                else
                begin
                    left_found_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_id_reg    <= '0;
            previous_valid_reg <= 1'b0;
            block_records_reg  <= '0;
            first_ref_reg      <= '0;
            first_mapped_reg   <= 1'b0;
            first_strand_reg   <= 1'b0;
            first_pos_reg      <= '0;
            left_found_reg     <= 1'b0;
            left_id_reg        <= '0;
            left_ref_reg       <= '0;
            left_strand_reg    <= 1'b0;
            left_pos_reg       <= '0;
        end
        else
        begin
            previous_id_reg    <= previous_id_next;
            previous_valid_reg <= previous_valid_next;
            block_records_reg  <= block_records_next;
            first_ref_reg      <= first_ref_next;
            first_mapped_reg   <= first_mapped_next;
            first_strand_reg   <= first_strand_next;
            first_pos_reg      <= first_pos_next;
            left_found_reg     <= left_found_next;
            left_id_reg        <= left_id_next;
            left_ref_reg       <= left_ref_next;
            left_strand_reg    <= left_strand_next;
            left_pos_reg       <= left_pos_next;
        end
    end

endmodule

### src/mpis_queue.sv
// Short queue of judged words between the front end and the accumulator.
module mpis_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mpis_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mpis_pkg::job_t pop_job
);

    mpis_pkg::job_t                  slot_reg [mpis_pkg::QUEUE_DEPTH];
    logic [mpis_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mpis_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mpis_pkg::QCNT_W-1:0]     fill_reg, fill_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (fill_reg != mpis_pkg::QCNT_W'(mpis_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mpis_pkg::QPTR_W'(mpis_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mpis_pkg::QPTR_W'(mpis_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### src/mpis_back.sv
// Back end: limit check and square, then saturating accumulation and result word.
module mpis_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mpis_pkg::cfg_regs_t cfg_regs,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  mpis_pkg::job_t      pop_job,
    mpis_res_if.source          res
);

    // stage 1: range check and square
    logic                               s1_valid_reg;
    logic                               s1_judged_reg;
    logic                               s1_accept_reg;
    logic signed [mpis_pkg::DIST_W-1:0] s1_dist_reg;
    logic [mpis_pkg::ACC_W-1:0]         s1_square_reg;

    // result stage
    logic                               out_valid_reg;
    logic                               out_accept_reg;
    logic signed [mpis_pkg::DIST_W-1:0] out_dist_reg;
    logic [mpis_pkg::CNT_W-1:0]         count_reg, count_next;
    logic signed [mpis_pkg::ACC_W-1:0]  sum_reg, sum_next;
    logic [mpis_pkg::ACC_W-1:0]         squares_reg, squares_next;

    logic                               out_free;
    logic                               s1_load;
    logic                               in_range;
    logic signed [mpis_pkg::DIST_W-1:0] neg_dist;
    logic [mpis_pkg::CNT_W-1:0]         mag;
    logic [mpis_pkg::ACC_W:0]           sum_wide;
    logic [mpis_pkg::ACC_W:0]           sq_wide;

    assign out_free  = !out_valid_reg || res.ready;
    assign s1_load   = !s1_valid_reg || out_free;
    assign pop_ready = s1_load;

    assign in_range = pop_job.judged
        && (pop_job.distance > $signed({cfg_regs.low_bound[31], cfg_regs.low_bound}))
        && (pop_job.distance < $signed({cfg_regs.high_bound[31], cfg_regs.high_bound}));
    assign neg_dist = -pop_job.distance;
    assign mag      = pop_job.distance[32] ? neg_dist[31:0] : pop_job.distance[31:0];

    always_ff @(posedge clk)
    begin
        if (s1_load && pop_valid)
        begin
            s1_judged_reg <= pop_job.judged;
            s1_accept_reg <= in_range;
            s1_dist_reg   <= pop_job.distance;
            s1_square_reg <= mag * mag;
        end
    end

    // saturating accumulation, one word per cycle while the result is not stalled
    always_comb
    begin
        sum_wide = {sum_reg[63], sum_reg} + {{32{s1_dist_reg[32]}}, s1_dist_reg};
        sq_wide  = {1'b0, squares_reg} + {1'b0, s1_square_reg};

        count_next   = count_reg;
        sum_next     = sum_reg;
        squares_next = squares_reg;
        if (s1_accept_reg)
        begin
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
            if (sum_wide[64] != sum_wide[63])
            begin
                sum_next = sum_wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                sum_next = $signed(sum_wide[63:0]);
            end
            squares_next = sq_wide[64] ? '1 : sq_wide[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            squares_reg   <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (out_free && s1_valid_reg)
            begin
                count_reg   <= count_next;
                sum_reg     <= sum_next;
                squares_reg <= squares_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_accept_reg <= s1_accept_reg;
            out_dist_reg   <= s1_judged_reg ? s1_dist_reg : '0;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.accepted           = out_accept_reg;
    assign res.distance           = out_dist_reg;
    assign res.sample_count       = count_reg;
    assign res.sample_sum         = sum_reg;
    assign res.sample_sum_squares = squares_reg;

endmodule
